@@ hw/rtl/fltw_pkg.sv @@
package fltw_pkg;

  // Fixed field widths
  localparam int unsigned DataW  = 64;
  localparam int unsigned VaW    = 48;
  localparam int unsigned PaW    = 52;
  localparam int unsigned LevelW = 2;

  // Default physical frame width of a table entry
  localparam int unsigned FrameAddrBitsDef = 36;

  // Entry attribute bits
  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

  // Operation codes on the request channel
  localparam logic OpStart = 1'b0;
  localparam logic OpEntry = 1'b1;

  // Result kinds
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // Walk levels
  localparam logic [LevelW-1:0] LevelTop  = 2'd0;
  localparam logic [LevelW-1:0] LevelGig  = 2'd1;
  localparam logic [LevelW-1:0] LevelTwoM = 2'd2;
  localparam logic [LevelW-1:0] LevelLeaf = 2'd3;

  // Walk state carried between transactions
  typedef struct packed {
    logic              busy;
    logic [LevelW-1:0] level;
    logic [VaW-1:0]    va;
  } walk_state_t;

  // One result transaction
  typedef struct packed {
    logic             kind;
    logic [DataW-1:0] read_address;
    logic [PaW-1:0]   phys_addr;
    logic             fault;
  } walk_result_t;

endpackage

@@ hw/rtl/fltw_step.sv @@
// Single-pass walk step: from the current walk state and one request
// transaction, work out the next state and at most one result.
module fltw_step #(
  parameter int unsigned FRAME_ADDR_BITS = fltw_pkg::FrameAddrBitsDef
) (
  input  fltw_pkg::walk_state_t              state_i,
  input  logic                               operation_i,
  input  logic [fltw_pkg::DataW-1:0]         table_base_i,
  input  logic [fltw_pkg::VaW-1:0]           virtual_address_i,
  input  logic [fltw_pkg::DataW-1:0]         entry_data_i,
  output fltw_pkg::walk_state_t              state_o,
  output logic                               res_valid_o,
  output fltw_pkg::walk_result_t             res_o
);

  logic [fltw_pkg::DataW-1:0] frame;
  logic [fltw_pkg::DataW-1:0] top_base;
  logic [fltw_pkg::PaW-1:0]   gig_pa;
  logic [fltw_pkg::PaW-1:0]   twom_pa;
  logic [fltw_pkg::PaW-1:0]   leaf_pa;
  logic [fltw_pkg::DataW-1:0] idx_gig;
  logic [fltw_pkg::DataW-1:0] idx_twom;
  logic [fltw_pkg::DataW-1:0] idx_leaf;
  logic [fltw_pkg::DataW-1:0] idx_top;
  logic                       present;
  logic                       huge_page;

  // Entry address offsets: 8 bytes per index
  assign idx_top  = {{(fltw_pkg::DataW-12){1'b0}}, virtual_address_i[47:39], 3'b000};
  assign idx_gig  = {{(fltw_pkg::DataW-12){1'b0}}, state_i.va[38:30], 3'b000};
  assign idx_twom = {{(fltw_pkg::DataW-12){1'b0}}, state_i.va[29:21], 3'b000};
  assign idx_leaf = {{(fltw_pkg::DataW-12){1'b0}}, state_i.va[20:12], 3'b000};

  assign top_base  = {table_base_i[fltw_pkg::DataW-1:4], 4'b0000};
  assign present   = entry_data_i[fltw_pkg::PresentBit];
  assign huge_page = entry_data_i[fltw_pkg::LargeBit];

  // Frame fields of the returned entry; page offsets never overlap them
  always_comb begin
    frame   = '0;
    frame[FRAME_ADDR_BITS-1:12] = entry_data_i[FRAME_ADDR_BITS-1:12];
    gig_pa  = {entry_data_i[51:30], state_i.va[29:0]};
    twom_pa = '0;
    twom_pa[FRAME_ADDR_BITS-1:21] = entry_data_i[FRAME_ADDR_BITS-1:21];
    twom_pa[20:0] = state_i.va[20:0];
    leaf_pa = frame[fltw_pkg::PaW-1:0] | {{(fltw_pkg::PaW-12){1'b0}}, state_i.va[11:0]};
  end

  // Next state and result
  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (operation_i == fltw_pkg::OpStart) begin
      state_o.busy       = 1'b1;
      state_o.level      = fltw_pkg::LevelTop;
      state_o.va         = virtual_address_i;
      res_valid_o        = 1'b1;
      res_o.kind         = fltw_pkg::KindRead;
      res_o.read_address = top_base + idx_top;
    end else if (state_i.busy) begin
      res_valid_o = 1'b1;
      // finishing transaction by default; overridden for a further read
      state_o.busy  = 1'b0;
      state_o.level = fltw_pkg::LevelTop;
      res_o.kind    = fltw_pkg::KindDone;
      unique case (state_i.level)
        fltw_pkg::LevelTop: begin
          if (!present) begin
            res_o.fault = 1'b1;
          end else begin
            state_o.busy       = 1'b1;
            state_o.level      = fltw_pkg::LevelGig;
            res_o.kind         = fltw_pkg::KindRead;
            res_o.read_address = frame + idx_gig;
          end
        end
        fltw_pkg::LevelGig: begin
          priority if (!present) begin
            res_o.fault = 1'b1;
          end else if (huge_page) begin
            res_o.phys_addr = gig_pa;
          end else begin
            state_o.busy       = 1'b1;
            state_o.level      = fltw_pkg::LevelTwoM;
            res_o.kind         = fltw_pkg::KindRead;
            res_o.read_address = frame + idx_twom;
          end
        end
        fltw_pkg::LevelTwoM: begin
          priority if (!present) begin
            res_o.fault = 1'b1;
          end else if (huge_page) begin
            res_o.phys_addr = twom_pa;
          end else begin
            state_o.busy       = 1'b1;
            state_o.level      = fltw_pkg::LevelLeaf;
            res_o.kind         = fltw_pkg::KindRead;
            res_o.read_address = frame + idx_leaf;
          end
        end
        fltw_pkg::LevelLeaf: begin
          // present bit is not looked at on the last level
          if (frame == '0) begin
            res_o.fault = 1'b1;
          end else begin
            res_o.phys_addr = leaf_pa;
          end
        end
        default: begin
          res_o.fault = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/four_level_page_table_walker.sv @@
// Four-level page table walker for 48-bit virtual addresses. A start
// transaction (operation 0) yields a read request for the top-level entry;
// each entry transaction (operation 1) yields either the next read request
// or a finished translation with a fault flag. A start while a walk is
// running abandons that walk; entry data while idle is dropped silently.
// Every transaction passes one input register, the single-pass step logic and
// one result register. A new transaction is accepted every cycle while
// results are being taken; the result register alone sets the rate.
module four_level_page_table_walker #(
  parameter int unsigned FRAME_ADDR_BITS = fltw_pkg::FrameAddrBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [fltw_pkg::DataW-1:0] table_base_i,
  input  logic [fltw_pkg::VaW-1:0]   virtual_address_i,
  input  logic [fltw_pkg::DataW-1:0] entry_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [fltw_pkg::DataW-1:0] read_address_o,
  output logic [fltw_pkg::PaW-1:0]   phys_addr_o,
  output logic                       fault_o
);

  // Input register
  logic                       in_valid_q;
  logic                       op_q;
  logic [fltw_pkg::DataW-1:0] base_q;
  logic [fltw_pkg::VaW-1:0]   va_q;
  logic [fltw_pkg::DataW-1:0] entry_q;

  // Walk state and result register
  fltw_pkg::walk_state_t  state_q, state_d;
  fltw_pkg::walk_result_t res_q, res_d;
  logic                   res_valid_d;
  logic                   out_valid_q;
  logic                   advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q    <= operation_i;
      base_q  <= table_base_i;
      va_q    <= virtual_address_i;
      entry_q <= entry_data_i;
    end
  end

  fltw_step #(
    .FRAME_ADDR_BITS(FRAME_ADDR_BITS)
  ) u_step (
    .state_i          (state_q),
    .operation_i      (op_q),
    .table_base_i     (base_q),
    .virtual_address_i(va_q),
    .entry_data_i     (entry_q),
    .state_o          (state_d),
    .res_valid_o      (res_valid_d),
    .res_o            (res_d)
  );

  // Walk state advances once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign read_address_o = res_q.read_address;
  assign phys_addr_o    = res_q.phys_addr;
  assign fault_o        = res_q.fault;

  // Checks
  a_start_opens_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == fltw_pkg::OpStart |=>
      state_q.busy && state_q.level == fltw_pkg::LevelTop)
    else $error("start transaction did not open a walk at the top level");

  a_done_closes_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid_d && res_d.kind == fltw_pkg::KindDone |=> !state_q.busy)
    else $error("walk still busy after a finished translation");

  a_fault_zero_pa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fault |-> res_q.kind == fltw_pkg::KindDone &&
      res_q.phys_addr == '0)
    else $error("fault result carries an address");

  a_idle_entry_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == fltw_pkg::OpEntry && !state_q.busy |=> !out_valid_q)
    else $error("entry data while idle produced a result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

endmodule

@@ sim/four_level_page_table_walker_tb.sv @@
`timescale 1ns / 100ps

module four_level_page_table_walker_tb;

  // Run shape
  localparam int unsigned RandomItems   = 800;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned HoldOffAt     = 300;
  localparam int unsigned PauseAt       = 550;
  localparam int unsigned DrainCycles   = 8;

  // Entry masks; the frame and 2MB masks at the default frame width
  localparam logic [fltw_pkg::DataW-1:0] FrameMask =
    ((64'd1 << fltw_pkg::FrameAddrBitsDef) - 64'd1) & ~64'hFFF;
  localparam logic [fltw_pkg::DataW-1:0] GigMask    = 64'h000F_FFFF_C000_0000;
  localparam logic [fltw_pkg::DataW-1:0] TwoMegMask = FrameMask & ~64'h1F_FFFF;

  // Where the expectation of a directed row comes from
  typedef enum logic [1:0] {
    ExpModel,
    ExpGiven,
    ExpNothing
  } exp_src_e;

  typedef struct {
    logic                       op;
    logic [fltw_pkg::DataW-1:0] base;
    logic [fltw_pkg::VaW-1:0]   va;
    logic [fltw_pkg::DataW-1:0] entry;
    exp_src_e                   src;
    fltw_pkg::walk_result_t     given;
  } walk_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       operation_i;
  logic [fltw_pkg::DataW-1:0] table_base_i;
  logic [fltw_pkg::VaW-1:0]   virtual_address_i;
  logic [fltw_pkg::DataW-1:0] entry_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       kind_o;
  logic [fltw_pkg::DataW-1:0] read_address_o;
  logic [fltw_pkg::PaW-1:0]   phys_addr_o;
  logic                       fault_o;

  fltw_pkg::walk_state_t      walk_st;
  fltw_pkg::walk_result_t     pending_results[$];
  walk_row_t                  walk_rows[$];
  int unsigned                mismatch_cnt = 0;
  bit                         hold_off_req = 1'b0;
  bit                         snd_no_gap   = 1'b0;

  four_level_page_table_walker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .table_base_i       (table_base_i),
    .virtual_address_i  (virtual_address_i),
    .entry_data_i       (entry_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .read_address_o     (read_address_o),
    .phys_addr_o        (phys_addr_o),
    .fault_o            (fault_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Overall time limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [fltw_pkg::DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [fltw_pkg::VaW-1:0] rand_va();
    logic [fltw_pkg::DataW-1:0] r;
    r = rand64();
    return r[fltw_pkg::VaW-1:0];
  endfunction

  // Byte offset of the 9-bit table index at the given shift
  function automatic logic [fltw_pkg::DataW-1:0] entry_offset(
    input logic [fltw_pkg::VaW-1:0] va, input int shift);
    logic [8:0] idx;
    idx = 9'(va >> shift);
    return {52'd0, idx, 3'b000};
  endfunction

  function automatic fltw_pkg::walk_result_t read_req(
    input logic [fltw_pkg::DataW-1:0] addr);
    fltw_pkg::walk_result_t r;
    r = '0;
    r.kind = fltw_pkg::KindRead;
    r.read_address = addr;
    return r;
  endfunction

  // Walk ends: back to idle, address zeroed on a fault
  function automatic fltw_pkg::walk_result_t finish_walk(
    input logic [fltw_pkg::DataW-1:0] pa, input bit flt);
    fltw_pkg::walk_result_t r;
    r = '0;
    walk_st.busy  = 1'b0;
    walk_st.level = fltw_pkg::LevelTop;
    r.kind = fltw_pkg::KindDone;
    r.phys_addr = flt ? '0 : pa[fltw_pkg::PaW-1:0];
    r.fault = flt;
    return r;
  endfunction

  // One walk step; returns 1 when the transaction yields a result
  function automatic bit walk_step(input logic op, input logic [fltw_pkg::DataW-1:0] base,
                                   input logic [fltw_pkg::VaW-1:0] va,
                                   input logic [fltw_pkg::DataW-1:0] ed,
                                   output fltw_pkg::walk_result_t res);
    logic [fltw_pkg::VaW-1:0] sva;
    res = '0;
    if (op == fltw_pkg::OpStart) begin
      walk_st.va    = va;
      walk_st.level = fltw_pkg::LevelTop;
      walk_st.busy  = 1'b1;
      res = read_req((base & ~64'hF) + entry_offset(va, 39));
      return 1'b1;
    end
    if (!walk_st.busy) return 1'b0;
    sva = walk_st.va;
    case (walk_st.level)
      fltw_pkg::LevelTop: begin
        if (!ed[fltw_pkg::PresentBit]) begin
          res = finish_walk('0, 1'b1);
        end else begin
          walk_st.level = fltw_pkg::LevelGig;
          res = read_req((ed & FrameMask) + entry_offset(sva, 30));
        end
      end
      fltw_pkg::LevelGig: begin
        if (!ed[fltw_pkg::PresentBit]) begin
          res = finish_walk('0, 1'b1);
        end else if (ed[fltw_pkg::LargeBit]) begin
          res = finish_walk((ed & GigMask) + {34'd0, sva[29:0]}, 1'b0);
        end else begin
          walk_st.level = fltw_pkg::LevelTwoM;
          res = read_req((ed & FrameMask) + entry_offset(sva, 21));
        end
      end
      fltw_pkg::LevelTwoM: begin
        if (!ed[fltw_pkg::PresentBit]) begin
          res = finish_walk('0, 1'b1);
        end else if (ed[fltw_pkg::LargeBit]) begin
          res = finish_walk((ed & TwoMegMask) + {43'd0, sva[20:0]}, 1'b0);
        end else begin
          walk_st.level = fltw_pkg::LevelLeaf;
          res = read_req((ed & FrameMask) + entry_offset(sva, 12));
        end
      end
      default: begin
        // last level: no present check, zero frame faults
        if ((ed & FrameMask) == '0) begin
          res = finish_walk('0, 1'b1);
        end else begin
          res = finish_walk((ed & FrameMask) + {52'd0, sva[11:0]}, 1'b0);
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void add_row(input logic op, input logic [fltw_pkg::DataW-1:0] base,
                                  input logic [fltw_pkg::VaW-1:0] va,
                                  input logic [fltw_pkg::DataW-1:0] ed,
                                  input exp_src_e src, input logic kind,
                                  input logic [fltw_pkg::DataW-1:0] ra,
                                  input logic [fltw_pkg::PaW-1:0] pa,
                                  input logic flt);
    walk_row_t row;
    row.op = op;
    row.base = base;
    row.va = va;
    row.entry = ed;
    row.src = src;
    row.given.kind = kind;
    row.given.read_address = ra;
    row.given.phys_addr = pa;
    row.given.fault = flt;
    walk_rows.push_back(row);
  endfunction

  // Offer one transaction, wait for it to be taken, record what it should yield
  task automatic send_txn(input logic op, input logic [fltw_pkg::DataW-1:0] base,
                          input logic [fltw_pkg::VaW-1:0] va,
                          input logic [fltw_pkg::DataW-1:0] ed,
                          input exp_src_e src, input fltw_pkg::walk_result_t given);
    int unsigned            gap;
    fltw_pkg::walk_result_t res;
    bit                     has_res;
    gap = (snd_no_gap || hold_off_req) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    table_base_i      <= base;
    virtual_address_i <= va;
    entry_data_i      <= ed;
    do @(posedge clk_i); while (!in_ready_o);
    has_res = walk_step(op, base, va, ed, res);
    if (src == ExpGiven) pending_results.push_back(given);
    else if (src == ExpModel && has_res) pending_results.push_back(res);
  endtask

  // Random entry for the current level
  function automatic logic [fltw_pkg::DataW-1:0] rand_entry();
    logic [fltw_pkg::DataW-1:0] ed;
    ed = rand64();
    ed[fltw_pkg::PresentBit] = ($urandom_range(0, 9) != 0);
    if (walk_st.level == fltw_pkg::LevelGig || walk_st.level == fltw_pkg::LevelTwoM)
      ed[fltw_pkg::LargeBit] = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 15) == 0) ed[51:12] = '0;
    else if (walk_st.level == fltw_pkg::LevelLeaf && $urandom_range(0, 7) == 0)
      ed[35:12] = '0;
    return ed;
  endfunction

  // Result sink with random back-pressure and long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned sink_cnt;
    bit          no_stall;
    sink_cnt = 0;
    no_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        stall = no_stall ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          @(negedge clk_i) out_ready_i <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
          @(negedge clk_i) out_ready_i <= 1'b1;
        end else if (!out_ready_i) begin
          @(negedge clk_i) out_ready_i <= 1'b1;
        end
      end
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      sink_cnt++;
      if (sink_cnt % 37 == 0) no_stall = 1'($urandom_range(0, 1));
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    fltw_pkg::walk_result_t got_res;
    fltw_pkg::walk_result_t want_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res.kind = kind_o;
      got_res.read_address = read_address_o;
      got_res.phys_addr = phys_addr_o;
      got_res.fault = fault_o;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: kind=%0d ra=%h pa=%h fault=%0d",
                   kind_o, read_address_o, phys_addr_o, fault_o);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: kind %0d/%0d ra %h/%h pa %h/%h fault %0d/%0d (exp/act)",
                     want_res.kind, got_res.kind, want_res.read_address,
                     got_res.read_address, want_res.phys_addr,
                     got_res.phys_addr, want_res.fault, got_res.fault);
        end
      end
    end
  end

  // Stimulus
  initial begin
    fltw_pkg::walk_result_t no_res;
    int unsigned            useful_items;
    int unsigned            pick;
    bit                     abandon;
    no_res = '0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    out_ready_i       = 1'b0;
    operation_i       = fltw_pkg::OpStart;
    table_base_i      = '0;
    virtual_address_i = '0;
    entry_data_i      = '0;
    walk_st           = '0;

    // entries while idle after reset are dropped
    add_row(fltw_pkg::OpEntry, '0, '0, '0, ExpNothing, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, '1, ExpNothing, fltw_pkg::KindRead, '0, '0, 1'b0);
    // all-ones base and address: entry address wraps
    add_row(fltw_pkg::OpStart, '1, '1, '0, ExpGiven, fltw_pkg::KindRead, 64'h0FE8, '0,
            1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, '0, ExpGiven, fltw_pkg::KindDone, '0, '0, 1'b1);
    add_row(fltw_pkg::OpStart, '0, '0, '0, ExpGiven, fltw_pkg::KindRead, '0, '0, 1'b0);
    // all-ones entries: 1GB page
    add_row(fltw_pkg::OpEntry, '0, '0, '1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, '1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    // zero 1GB frame
    add_row(fltw_pkg::OpStart, 64'h1234_5678_9ABC_DEFF, 48'h8765_4321_0FED, '0, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h81, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    // zero 2MB frame
    add_row(fltw_pkg::OpStart, 64'hFEDC_BA98_7654_3210, 48'h0000_FFFF_0000, '0, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h81, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    // start while busy restarts the walk
    add_row(fltw_pkg::OpStart, '0, '1, '0, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h3, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpStart, 64'h8000_0000_0000_000F, 48'h7FFF_FFFF_FFFF, '0, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    // full 4KB walk, last entry not present but mapped
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1000_0001, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h2000_0001, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h3000_0001, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    // zero last frame faults
    add_row(fltw_pkg::OpStart, 64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA, '0, ExpModel,
            fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1, ExpModel, fltw_pkg::KindRead, '0, '0, 1'b0);
    add_row(fltw_pkg::OpEntry, '0, '0, 64'h1, ExpGiven, fltw_pkg::KindDone, '0, '0, 1'b1);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table
    foreach (walk_rows[i])
      send_txn(walk_rows[i].op, walk_rows[i].base, walk_rows[i].va, walk_rows[i].entry,
               walk_rows[i].src, walk_rows[i].given);

    // Random walks with some noise
    useful_items = 0;
    while (useful_items < RandomItems) begin
      if (useful_items >= HoldOffAt && useful_items < HoldOffAt + 5) hold_off_req = 1'b1;
      if (useful_items >= PauseAt && useful_items < PauseAt + 5) begin
        // withdraw the last transaction before waiting for the block to empty
        @(negedge clk_i) in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) snd_no_gap = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if (walk_st.busy) useful_items++;
        send_txn(fltw_pkg::OpEntry, rand64(), rand_va(), rand64(), ExpModel, no_res);
      end else begin
        send_txn(fltw_pkg::OpStart, rand64(), rand_va(), rand64(), ExpModel, no_res);
        useful_items++;
        abandon = 1'b0;
        while (walk_st.busy && !abandon) begin
          if ($urandom_range(0, 99) < 4) begin
            abandon = 1'b1;
          end else begin
            send_txn(fltw_pkg::OpEntry, rand64(), rand_va(), rand_entry(), ExpModel,
                     no_res);
            useful_items++;
          end
        end
      end
    end
    @(negedge clk_i) in_valid_i <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
